// ===== hw/rtl/blq_pkg.sv =====
`default_nettype none

package blq_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int MV_W        = 16;
    localparam int DWELL_W     = 32;
    localparam int TIME_W      = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_CRITICAL_LEVEL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_LEVEL      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RESUME_LEVEL   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_DWELL      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RESUME_DWELL   = 3'd4;

    localparam logic [MV_W-1:0]    RST_CRITICAL_LEVEL = 16'd3000;
    localparam logic [MV_W-1:0]    RST_LOW_LEVEL      = 16'd3300;
    localparam logic [MV_W-1:0]    RST_RESUME_LEVEL   = 16'd3600;
    localparam logic [DWELL_W-1:0] RST_LOW_DWELL      = 32'd5000;
    localparam logic [DWELL_W-1:0] RST_RESUME_DWELL   = 32'd10000;

    typedef enum logic [2:0] {
        ST_NORMAL    = 3'd0,
        ST_LOW       = 3'd1,
        ST_CRITICAL  = 3'd2,
        ST_RECOVERED = 3'd3,
        ST_INVALID   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        LVL_NORMAL   = 2'd0,
        LVL_LOW      = 2'd1,
        LVL_CRITICAL = 2'd2
    } level_t;

    typedef struct packed {
        logic [MV_W-1:0]   sample_mv;
        logic              sample_valid;
        logic [TIME_W-1:0] timestamp_ms;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic       is_stable;
    } out_item_t;

    typedef struct packed {
        logic [MV_W-1:0]    critical_level_mv;
        logic [MV_W-1:0]    low_level_mv;
        logic [MV_W-1:0]    resume_level_mv;
        logic [DWELL_W-1:0] low_dwell_ms;
        logic [DWELL_W-1:0] resume_dwell_ms;
        logic               ok;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/battery_level_qualifier_unit.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_item (in_item_t)
// out      output     out_valid / out_stall out_item (out_item_t)
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Input then result register; one sample per clock while out_stall is low.
// The input register feeds the evaluation logic; state and the result
// register update together when the result register is free.
// out_stall holds the result register and, once the input register is full,
// raises in_stall in the same cycle. cfg_ready is always high.
// Reset is asynchronous; thresholds return to their defaults.
`default_nettype none

module battery_level_qualifier_unit
    import blq_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_item_t               in_item,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_item_t                   out_item,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t      cfg;
    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t result;
    logic      out_free;
    logic      step;
    logic      in_take;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign step      = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;

    blq_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    blq_eval u_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .item   (s1_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_take;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_item;
        end
        if (step)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/blq_cfg_regs.sv =====
`default_nettype none

module blq_cfg_regs
    import blq_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                        cfg
);

    logic [MV_W-1:0]    critical_reg;
    logic [MV_W-1:0]    low_reg;
    logic [MV_W-1:0]    resume_reg;
    logic [DWELL_W-1:0] low_dwell_reg;
    logic [DWELL_W-1:0] resume_dwell_reg;
    logic               ok_reg;
    logic               ok_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            critical_reg     <= RST_CRITICAL_LEVEL;
            low_reg          <= RST_LOW_LEVEL;
            resume_reg       <= RST_RESUME_LEVEL;
            low_dwell_reg    <= RST_LOW_DWELL;
            resume_dwell_reg <= RST_RESUME_DWELL;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_CRITICAL_LEVEL: critical_reg     <= wr_data[MV_W-1:0];
                REG_LOW_LEVEL:      low_reg          <= wr_data[MV_W-1:0];
                REG_RESUME_LEVEL:   resume_reg       <= wr_data[MV_W-1:0];
                REG_LOW_DWELL:      low_dwell_reg    <= wr_data[DWELL_W-1:0];
                REG_RESUME_DWELL:   resume_dwell_reg <= wr_data[DWELL_W-1:0];
                default:            ;
            endcase
        end
    end

    // ordering check, registered; writes must only happen while idle, which the block does not enforce
    assign ok_next = (critical_reg != '0) && (critical_reg < low_reg) &&
                     (low_reg < resume_reg) && (low_dwell_reg != '0) &&
                     (resume_dwell_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= 1'b1;
        end
        else
        begin
            ok_reg <= ok_next;
        end
    end

    always_comb
    begin
        cfg.critical_level_mv = critical_reg;
        cfg.low_level_mv      = low_reg;
        cfg.resume_level_mv   = resume_reg;
        cfg.low_dwell_ms      = low_dwell_reg;
        cfg.resume_dwell_ms   = resume_dwell_reg;
        cfg.ok                = ok_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/blq_eval.sv =====
`default_nettype none

module blq_eval
    import blq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      step,
    input  wire in_item_t  item,
    output out_item_t      result
);

    level_t            level_reg, level_next;
    logic [TIME_W-1:0] last_time_reg, last_time_next;
    logic              time_seen_reg, time_seen_next;
    logic              stable_reg, stable_next;
    logic              low_run_reg, low_run_next;
    logic [TIME_W-1:0] low_start_reg, low_start_next;
    logic              res_run_reg, res_run_next;
    logic [TIME_W-1:0] res_start_reg, res_start_next;

    logic [TIME_W-1:0] now;
    logic [MV_W-1:0]   mv;
    logic              latched;
    logic [TIME_W-1:0] start_sel;
    logic [TIME_W-1:0] dwell_sel;
    logic [TIME_W-1:0] elapsed;
    logic              dwell_met;

    assign now     = item.timestamp_ms;
    assign mv      = item.sample_mv;
    assign latched = (level_reg != LVL_NORMAL);

    // one shared elapsed-time subtract; a timer not yet running starts now
    always_comb
    begin
        if (latched)
        begin
            start_sel = res_run_reg ? res_start_reg : now;
            dwell_sel = {{(TIME_W-DWELL_W){1'b0}}, cfg.resume_dwell_ms};
        end
        else
        begin
            start_sel = low_run_reg ? low_start_reg : now;
            dwell_sel = {{(TIME_W-DWELL_W){1'b0}}, cfg.low_dwell_ms};
        end
        elapsed   = now - start_sel;
        dwell_met = (elapsed >= dwell_sel);
    end

    always_comb
    begin
        level_next     = level_reg;
        last_time_next = last_time_reg;
        time_seen_next = time_seen_reg;
        stable_next    = stable_reg;
        low_run_next   = low_run_reg;
        low_start_next = low_start_reg;
        res_run_next   = res_run_reg;
        res_start_next = res_start_reg;
        result.status    = ST_INVALID;
        result.is_stable = 1'b0;

        if (!cfg.ok)
        begin
            result.status    = ST_INVALID;
            result.is_stable = 1'b0;
        end
        else if (time_seen_reg && (now < last_time_reg))
        begin
            result.status    = ST_INVALID;
            result.is_stable = stable_reg;
        end
        else
        begin
            time_seen_next = 1'b1;
            last_time_next = now;
            if (!item.sample_valid)
            begin
                stable_next   = 1'b0;
                low_run_next  = 1'b0;
                res_run_next  = 1'b0;
                result.status = ST_INVALID;
            end
            else if (mv <= cfg.critical_level_mv)
            begin
                level_next    = LVL_CRITICAL;
                stable_next   = 1'b1;
                res_run_next  = 1'b0;
                result.status = ST_CRITICAL;
            end
            else if (latched)
            begin
                stable_next   = 1'b1;
                result.status = status_t'({1'b0, level_reg});
                if (mv < cfg.resume_level_mv)
                begin
                    res_run_next = 1'b0;
                end
                else
                begin
                    res_run_next   = 1'b1;
                    res_start_next = start_sel;
                    if (dwell_met)
                    begin
                        level_next    = LVL_NORMAL;
                        res_run_next  = 1'b0;
                        low_run_next  = 1'b0;
                        result.status = ST_RECOVERED;
                    end
                end
            end
            else
            begin
                result.status = ST_NORMAL;
                if (mv > cfg.low_level_mv)
                begin
                    stable_next  = 1'b1;
                    low_run_next = 1'b0;
                end
                else
                begin
                    low_run_next   = 1'b1;
                    low_start_next = start_sel;
                    if (dwell_met)
                    begin
                        level_next    = LVL_LOW;
                        stable_next   = 1'b1;
                        result.status = ST_LOW;
                    end
                end
            end
            result.is_stable = stable_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= LVL_NORMAL;
            last_time_reg <= '0;
            time_seen_reg <= 1'b0;
            stable_reg    <= 1'b0;
            low_run_reg   <= 1'b0;
            low_start_reg <= '0;
            res_run_reg   <= 1'b0;
            res_start_reg <= '0;
        end
        else if (step)
        begin
            level_reg     <= level_next;
            last_time_reg <= last_time_next;
            time_seen_reg <= time_seen_next;
            stable_reg    <= stable_next;
            low_run_reg   <= low_run_next;
            low_start_reg <= low_start_next;
            res_run_reg   <= res_run_next;
            res_start_reg <= res_start_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/blq_checker.sv =====
`default_nettype none

module blq_checker
    import blq_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
    else $error("accepted sample did not reach the result register");

    a_latched_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == ST_LOW || out_item.status == ST_CRITICAL ||
                      out_item.status == ST_RECOVERED) |-> out_item.is_stable)
    else $error("latched or recovered status without stable flag");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

endmodule

bind battery_level_qualifier_unit blq_checker u_blq_checker (.*);

`default_nettype wire

// ===== dv/battery_level_qualifier_unit_tb.sv =====
`timescale 1ns / 100ps

module battery_level_qualifier_unit_tb;
    import blq_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int QUIET_LIMIT = 1000;
    localparam int LONG_HOLD   = 60;
    localparam int DRAIN_WAIT  = 10;

    typedef struct {
        bit                     is_cfg;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        in_item_t               smp;
        bit                     typed;
        out_item_t              want;
    } sample_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    in_item_t               in_item;
    logic                   out_valid;
    logic                   out_stall;
    out_item_t              out_item;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // predictor copies of thresholds and monitor state
    logic [MV_W-1:0]    crit_mv      = RST_CRITICAL_LEVEL;
    logic [MV_W-1:0]    low_mv       = RST_LOW_LEVEL;
    logic [MV_W-1:0]    rsm_lvl      = RST_RESUME_LEVEL;
    logic [DWELL_W-1:0] low_dwell    = RST_LOW_DWELL;
    logic [DWELL_W-1:0] resume_dwell = RST_RESUME_DWELL;
    level_t             lvl_q        = LVL_NORMAL;
    logic [TIME_W-1:0]  last_ms      = '0;
    bit                 seen_time    = 1'b0;
    bit                 stable_now   = 1'b0;
    bit                 low_armed    = 1'b0;
    logic [TIME_W-1:0]  low_t0       = '0;
    bit                 resume_armed = 1'b0;
    logic [TIME_W-1:0]  resume_t0    = '0;

    out_item_t          pending_status[$];
    sample_row_t        dir_tab[$];
    sample_row_t        tail_tab[$];
    int                 mismatches   = 0;
    int                 quiet_cycles = 0;
    bit                 in_burst     = 1'b0;
    bit                 out_burst    = 1'b0;
    bit                 long_hold    = 1'b0;
    logic [TIME_W-1:0]  gen_ms       = 64'd41000;

    battery_level_qualifier_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    function automatic out_item_t qualify_sample(in_item_t s);
        out_item_t r;
        bit        cfg_good;
        cfg_good = crit_mv != 0 && crit_mv < low_mv && low_mv < rsm_lvl &&
                   low_dwell != 0 && resume_dwell != 0;
        r.is_stable = 1'b0;
        if (!cfg_good)
            r.status = ST_INVALID;
        else if (seen_time && s.timestamp_ms < last_ms)
        begin
            r.status    = ST_INVALID;
            r.is_stable = stable_now;
        end
        else
        begin
            seen_time = 1'b1;
            last_ms   = s.timestamp_ms;
            if (!s.sample_valid)
            begin
                stable_now   = 1'b0;
                low_armed    = 1'b0;
                resume_armed = 1'b0;
                r.status     = ST_INVALID;
            end
            else if (s.sample_mv <= crit_mv)
            begin
                lvl_q        = LVL_CRITICAL;
                stable_now   = 1'b1;
                resume_armed = 1'b0;
                r.status     = ST_CRITICAL;
            end
            else if (lvl_q != LVL_NORMAL)
            begin
                stable_now = 1'b1;
                r.status   = (lvl_q == LVL_LOW) ? ST_LOW : ST_CRITICAL;
                if (s.sample_mv < rsm_lvl)
                    resume_armed = 1'b0;
                else
                begin
                    if (!resume_armed)
                    begin
                        resume_armed = 1'b1;
                        resume_t0    = s.timestamp_ms;
                    end
                    if (s.timestamp_ms - resume_t0 >= TIME_W'(resume_dwell))
                    begin
                        lvl_q        = LVL_NORMAL;
                        resume_armed = 1'b0;
                        low_armed    = 1'b0;
                        r.status     = ST_RECOVERED;
                    end
                end
            end
            else
            begin
                if (s.sample_mv > low_mv)
                begin
                    stable_now = 1'b1;
                    low_armed  = 1'b0;
                end
                else
                begin
                    if (!low_armed)
                    begin
                        low_armed = 1'b1;
                        low_t0    = s.timestamp_ms;
                    end
                    if (s.timestamp_ms - low_t0 >= TIME_W'(low_dwell))
                    begin
                        lvl_q      = LVL_LOW;
                        stable_now = 1'b1;
                    end
                end
                r.status = (lvl_q == LVL_LOW) ? ST_LOW : ST_NORMAL;
            end
            r.is_stable = stable_now;
        end
        return r;
    endfunction

    function automatic sample_row_t row(logic [MV_W-1:0] mv, logic vld, logic [TIME_W-1:0] ts);
        sample_row_t r;
        r.is_cfg             = 1'b0;
        r.idx                = REG_CRITICAL_LEVEL;
        r.data               = '0;
        r.smp.sample_mv      = mv;
        r.smp.sample_valid   = vld;
        r.smp.timestamp_ms   = ts;
        r.typed              = 1'b0;
        r.want               = '0;
        return r;
    endfunction

    function automatic sample_row_t chk_row(logic [MV_W-1:0] mv, logic vld,
                                            logic [TIME_W-1:0] ts, status_t st, logic stb);
        sample_row_t r;
        r                = row(mv, vld, ts);
        r.typed          = 1'b1;
        r.want.status    = st;
        r.want.is_stable = stb;
        return r;
    endfunction

    function automatic sample_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
        sample_row_t r;
        r        = row('0, 1'b0, '0);
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic logic [MV_W-1:0] mv_in_region(int unsigned rg);
        int unsigned lo;
        int unsigned hi;
        case (rg)
            0:
            begin
                lo = 0;
                hi = 32'(crit_mv);
            end
            1:
            begin
                lo = crit_mv + 1;
                hi = 32'(low_mv);
            end
            2:
            begin
                lo = low_mv + 1;
                hi = rsm_lvl - 1;
            end
            default:
            begin
                lo = 32'(rsm_lvl);
                hi = 'hFFFF;
            end
        endcase
        if (lo > hi)
            return MV_W'($urandom);
        return MV_W'($urandom_range(hi, lo));
    endfunction

    // caller sits at a falling edge; returns at a falling edge with valid still high
    task automatic send_sample(input in_item_t s, input bit typed, input out_item_t want);
        int        gap;
        out_item_t got;
        gap = in_burst ? 0 : $urandom_range(10, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= s;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        got = qualify_sample(s);
        pending_status.push_back(typed ? want : got);
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_status.size() != 0);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            REG_CRITICAL_LEVEL: crit_mv      = data[MV_W-1:0];
            REG_LOW_LEVEL:      low_mv       = data[MV_W-1:0];
            REG_RESUME_LEVEL:   rsm_lvl      = data[MV_W-1:0];
            REG_LOW_DWELL:      low_dwell    = data[DWELL_W-1:0];
            REG_RESUME_DWELL:   resume_dwell = data[DWELL_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic walk_table(input sample_row_t tab[$]);
        foreach (tab[i])
        begin
            if (tab[i].is_cfg)
            begin
                wait_results_drained();
                write_cfg(tab[i].idx, tab[i].data);
            end
            else
                send_sample(tab[i].smp, tab[i].typed, tab[i].want);
        end
    endtask

    // 16-bit thresholds carry random upper bits, which the block drops
    task automatic set_config(input logic [MV_W-1:0] c, input logic [MV_W-1:0] l,
                              input logic [MV_W-1:0] r, input logic [DWELL_W-1:0] ld,
                              input logic [DWELL_W-1:0] rd);
        logic [CFG_DATA_W-1:0] pad;
        wait_results_drained();
        pad = $urandom;
        write_cfg(REG_CRITICAL_LEVEL, {pad[31:16], c});
        pad = $urandom;
        write_cfg(REG_LOW_LEVEL, {pad[31:16], l});
        pad = $urandom;
        write_cfg(REG_RESUME_LEVEL, {pad[31:16], r});
        write_cfg(REG_LOW_DWELL, ld);
        write_cfg(REG_RESUME_DWELL, rd);
        write_cfg(CFG_INDEX_W'($urandom_range((1 << CFG_INDEX_W) - 1, REG_RESUME_DWELL + 1)),
                  $urandom);
    endtask

    // runs of samples in one voltage band, with some invalid and out-of-order noise
    task automatic run_phase(input logic [MV_W-1:0] c, input logic [MV_W-1:0] l,
                             input logic [MV_W-1:0] r, input logic [DWELL_W-1:0] ld,
                             input logic [DWELL_W-1:0] rd, input int n);
        int unsigned       kind;
        int unsigned       region;
        int unsigned       run_left;
        int unsigned       span;
        logic [TIME_W-1:0] step;
        in_item_t          s;
        set_config(c, l, r, ld, rd);
        run_left = 0;
        region   = 0;
        span     = (ld > rd) ? ld : rd;
        if (span == 0)
            span = 1000;
        for (int k = 0; k < n; k++)
        begin
            if (run_left == 0)
            begin
                region   = $urandom_range(3, 0);
                run_left = $urandom_range(12, 2);
            end
            run_left--;
            kind = $urandom_range(99, 0);
            case ($urandom_range(9, 0))
                0:       step = '0;
                1:       step = TIME_W'(span);
                default: step = TIME_W'($urandom_range(span / 3 + 1, 0));
            endcase
            s.sample_valid = (kind >= 5);
            s.sample_mv    = (kind < 10) ? MV_W'($urandom) : mv_in_region(region);
            if (kind >= 5 && kind < 10 && gen_ms != 0)
                s.timestamp_ms = {$urandom, $urandom} % gen_ms;
            else
            begin
                gen_ms         = gen_ms + step;
                s.timestamp_ms = gen_ms;
            end
            send_sample(s, 1'b0, '0);
        end
    endtask

    task automatic run_random_phase(input int n);
        logic [MV_W-1:0] c;
        logic [MV_W-1:0] l;
        logic [MV_W-1:0] r;
        c = MV_W'($urandom_range(60000, 1));
        l = c + MV_W'($urandom_range(2000, 1));
        r = l + MV_W'($urandom_range(2000, 1));
        run_phase(c, l, r, $urandom_range(2000, 1), $urandom_range(2000, 1), n);
    endtask

    // receiver
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                n = LONG_HOLD;
            end
            else
                n = out_burst ? 0 : $urandom_range(10, 0);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_status.size() == 0)
            begin
                $display("%0t: unexpected transaction: status %0d stable %0b",
                         $time, out_item.status, out_item.is_stable);
                mismatches++;
            end
            else
            begin
                want = pending_status.pop_front();
                if (out_item.status !== want.status)
                begin
                    $display("%0t: status expected %0d, actual %0d",
                             $time, want.status, out_item.status);
                    mismatches++;
                end
                if (out_item.is_stable !== want.is_stable)
                begin
                    $display("%0t: is_stable expected %0b, actual %0b",
                             $time, want.is_stable, out_item.is_stable);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[battery_level_qualifier_unit] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_CRITICAL_LEVEL;
        cfg_data  = '0;

        dir_tab.push_back(chk_row(16'd3500,  1'b1, 64'd0,     ST_NORMAL,   1'b1));
        dir_tab.push_back(chk_row(16'd0,     1'b1, 64'd10,    ST_CRITICAL, 1'b1));
        dir_tab.push_back(row(16'hFFFF, 1'b1, 64'd20));
        dir_tab.push_back(row(16'hFFFF, 1'b1, 64'd10019));
        dir_tab.push_back(row(16'hFFFF, 1'b1, 64'd10020));
        dir_tab.push_back(chk_row(16'd3500,  1'b1, 64'd5,     ST_INVALID,  1'b1));
        dir_tab.push_back(chk_row(16'd3500,  1'b0, 64'd10030, ST_INVALID,  1'b0));
        dir_tab.push_back(chk_row(16'd3500,  1'b1, 64'd100,   ST_INVALID,  1'b0));
        dir_tab.push_back(row(16'd3300, 1'b1, 64'd20000));
        dir_tab.push_back(row(16'd3001, 1'b1, 64'd24999));
        dir_tab.push_back(row(16'd3300, 1'b1, 64'd25000));
        dir_tab.push_back(row(16'd3599, 1'b1, 64'd26000));
        dir_tab.push_back(row(16'd3600, 1'b1, 64'd27000));
        dir_tab.push_back(row(16'd3599, 1'b1, 64'd28000));
        dir_tab.push_back(row(16'd3600, 1'b1, 64'd30000));
        dir_tab.push_back(row(16'd3600, 1'b1, 64'd39999));
        dir_tab.push_back(row(16'd3600, 1'b1, 64'd40000));
        dir_tab.push_back(chk_row(16'd3000,  1'b1, 64'd40000, ST_CRITICAL, 1'b1));
        dir_tab.push_back(row(16'd3001, 1'b1, 64'd40001));
        dir_tab.push_back(chk_row(16'd0,     1'b0, 64'd40002, ST_INVALID,  1'b0));
        dir_tab.push_back(row(16'd0,    1'b1, 64'd40003));
        dir_tab.push_back(cfg_row(REG_CRITICAL_LEVEL, 32'd3300));
        dir_tab.push_back(chk_row(16'd0,     1'b1, 64'd40004, ST_INVALID,  1'b0));
        dir_tab.push_back(cfg_row(REG_CRITICAL_LEVEL, 32'(RST_CRITICAL_LEVEL)));
        dir_tab.push_back(row(16'd3500, 1'b1, 64'd40005));

        // top of the time range, run last since time never goes back
        tail_tab.push_back(row(16'hFFFF, 1'b1, 64'hFFFF_FFFF_0000_0000));
        tail_tab.push_back(row(16'd3300, 1'b1, 64'hFFFF_FFFF_0000_0001));
        tail_tab.push_back(row(16'd3300, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
        tail_tab.push_back(row(16'hFFFF, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
        tail_tab.push_back(row(16'd3500, 1'b1, 64'd0));

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        walk_table(dir_tab);

        run_phase(RST_CRITICAL_LEVEL, RST_LOW_LEVEL, RST_RESUME_LEVEL,
                  RST_LOW_DWELL, RST_RESUME_DWELL, 100);
        in_burst = 1'b1;
        run_phase(16'd1, 16'd2, 16'd3, 32'd1, 32'd1, 100);
        in_burst  = 1'b0;
        out_burst = 1'b1;
        run_phase(16'hFFFD, 16'hFFFE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 100);
        out_burst = 1'b0;
        run_phase(16'd0, 16'd3300, 16'd3600, 32'd5000, 32'd10000, 40);
        wait_results_drained();
        in_burst  = 1'b1;
        long_hold = 1'b1;
        run_random_phase(100);
        in_burst = 1'b0;
        run_phase(16'd3300, 16'd3300, 16'd3600, 32'd5000, 32'd10000, 40);
        run_phase(16'd3000, 16'd3600, 16'd3600, 32'd5000, 32'd10000, 30);
        run_phase(16'd3000, 16'd3300, 16'd3600, 32'd0, 32'd10000, 30);
        run_phase(16'd3000, 16'd3300, 16'd3600, 32'd5000, 32'd0, 30);
        in_burst  = 1'b1;
        out_burst = 1'b1;
        run_random_phase(100);
        in_burst  = 1'b0;
        out_burst = 1'b0;
        run_random_phase(130);

        set_config(RST_CRITICAL_LEVEL, RST_LOW_LEVEL, RST_RESUME_LEVEL,
                   RST_LOW_DWELL, RST_RESUME_DWELL);
        walk_table(tail_tab);

        wait_results_drained();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (mismatches == 0)
            $display("[battery_level_qualifier_unit] OK");
        else
            $display("[battery_level_qualifier_unit] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/blq_pkg.sv
hw/rtl/blq_cfg_regs.sv
hw/rtl/blq_eval.sv
hw/rtl/battery_level_qualifier_unit.sv
hw/rtl/blq_checker.sv
dv/battery_level_qualifier_unit_tb.sv
